>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL. The simulation form checks the property
// on every rising clock edge outside reset; the synthesis form is empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define WRN_ASSERT_IMP(name, ck, rn, a, c) \
    name: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) \
        else $error("assertion failed");

`define WRN_ASSERT_NXT(name, ck, rn, a, c) \
    name: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) \
        else $error("assertion failed");

`else

`define WRN_ASSERT_IMP(name, ck, rn, a, c)

`define WRN_ASSERT_NXT(name, ck, rn, a, c)

`endif

`endif

>>> hdl/wrn_pkg.sv
`default_nettype none
package wrn_pkg;

    localparam int ADDR_W = 3;

    localparam logic REG_UPDATE_ENABLE = 1'b0;
    localparam logic REG_VECTOR_LENGTH = 1'b1;

    localparam logic [63:0] SUM_ONE = 64'h0000_0001_0000_0000;
    localparam logic [31:0] VAR_ONE = 32'h0001_0000;

    typedef struct packed {
        logic [31:0] mean;
        logic [63:0] sum;
        logic [31:0] variance;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
        logic [6:0]  iters;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [47:0] radicand;
    } sq_req_t;

    typedef struct packed {
        logic        done;
        logic [23:0] root;
    } sq_rsp_t;

endpackage
`default_nettype wire

>>> hdl/wrn_if.sv
`default_nettype none
interface wrn_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface wrn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] normalized;
    logic [5:0]         element_index;
    logic               last_of_vector;
    logic               zero_variance;

    modport source (output valid, output normalized, output element_index,
                    output last_of_vector, output zero_variance, input ready);
    modport sink (input valid, input normalized, input element_index,
                  input last_of_vector, input zero_variance, output ready);
endinterface
`default_nettype wire

>>> hdl/wrn_ram.sv
`default_nettype none
module wrn_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> hdl/wrn_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned so that the number of iterations equals its significant width.
module wrn_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wrn_pkg::div_req_t req,
    output wrn_pkg::div_rsp_t      rsp
);
    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] divisor_reg;
    logic [63:0] dvd_reg;
    logic [63:0] quo_reg;

    logic [32:0] trial;
    logic        ge;
    logic [31:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[63]};
        ge       = trial >= {1'b0, divisor_reg};
        rem_next = ge ? 32'(trial - {1'b0, divisor_reg}) : trial[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg    <= 1'b1;
            cnt_reg     <= req.iters;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
            dvd_reg     <= req.dividend;
            quo_reg     <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            quo_reg <= {quo_reg[62:0], ge};
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign rsp.done     = !busy_reg && !req.start;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

>>> hdl/wrn_sqrt.sv
`default_nettype none
// Digit-by-digit integer square root of a 48-bit value, one root bit per cycle.
module wrn_sqrt (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire wrn_pkg::sq_req_t req,
    output wrn_pkg::sq_rsp_t      rsp
);
    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [47:0] rad_reg;
    logic [25:0] rem_reg;
    logic [23:0] root_reg;

    logic [27:0] pulled;
    logic [27:0] trial;
    logic        ge;

    always_comb
    begin
        pulled = {rem_reg, rad_reg[47:46]};
        trial  = {2'b00, root_reg, 2'b01};
        ge     = pulled >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd24;
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? 26'(pulled - trial) : pulled[25:0];
            root_reg <= {root_reg[22:0], ge};
            rad_reg  <= {rad_reg[45:0], 2'b00};
            cnt_reg  <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign rsp.done = !busy_reg && !req.start;
    assign rsp.root = root_reg;
endmodule
`default_nettype wire

>>> hdl/welford_running_normalizer_top.sv
// Running mean/variance normalizer for Q16.16 observation vectors.
// Input channel in_ch carries one vector element per item; the block counts
// the dimension itself; a vector holds vector_length clamped to 1..MAX_DIMENSIONS.
// Output channel out_ch returns one item per input item: the normalized value,
// its dimension, an end-of-vector mark and a zero-variance flag.
// Configuration goes through the APB port: update_enable at 0x0, vector_length
// at 0x4. Write them only while no item is in flight.
// Per-dimension statistics live in one RAM; every item is read, updated and
// written back before the next one is taken. A shared divider (one bit per
// cycle) and a square-root unit (one bit per cycle) set the pace; an item
// takes longer when statistics update than on a first step or when only
// normalizing. in_ch.ready is high while the block is idle.
// After reset a clearing pass writes the initial statistics to every RAM
// entry; no item is taken during that pass.
// A finished result waits in the output register; while out_ch stalls, the
// block still takes and works on the next item, then waits to hand it over.
`default_nettype none
`include "assert_macros.svh"
module welford_running_normalizer_top #(
    parameter int MAX_DIMENSIONS = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    wrn_in_if.sink                          in_ch,
    wrn_out_if.source                       out_ch,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [wrn_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);
    localparam int IDX_W = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
    localparam int CW    = (IDX_W + 1 > 7) ? IDX_W + 1 : 7;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_DIV1, S_MUL, S_SUM, S_DIV2,
        S_WRITE, S_SQRT, S_DIV3, S_DONE
    } state_t;

    state_t state_reg;

    logic        update_enable_reg;
    logic [6:0]  vector_length_reg;

    logic [IDX_W-1:0] clr_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             last_reg;
    logic [31:0]      step_reg;
    logic [31:0]      x_reg;
    logic [31:0]      mean_reg;
    logic [63:0]      sum_reg;
    logic [31:0]      var_reg;
    logic             d1neg_reg;
    logic [31:0]      mag1_reg;
    logic             d2neg_reg;
    logic [31:0]      mag2_reg;
    logic [63:0]      prod_reg;
    logic [31:0]      res_reg;
    logic             zero_reg;

    logic        out_valid_reg;
    logic [31:0] out_norm_reg;
    logic [5:0]  out_idx_reg;
    logic        out_last_reg;
    logic        out_zero_reg;

    wrn_pkg::div_req_t div_req_reg;
    wrn_pkg::div_rsp_t div_rsp;
    wrn_pkg::sq_req_t  sq_req_reg;
    wrn_pkg::sq_rsp_t  sq_rsp;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    wrn_pkg::entry_t     ram_wdata;
    logic                ram_re;
    wrn_pkg::entry_t     ram_rdata;

    logic             cfg_write;
    logic             accept;
    logic [CW-1:0]    len_c;
    logic             last_now;
    logic [32:0]      d_load;
    logic [32:0]      d_new;
    logic [32:0]      d_norm;
    logic [31:0]      q32;
    logic [31:0]      new_mean;
    logic             add_sum;
    logic [64:0]      sum_add;
    logic [63:0]      sum_new;
    logic [47:0]      var_full;
    logic [47:0]      q48;

    // Signed difference of two Q16.16 values, one bit wider so it cannot wrap.
    function automatic logic [32:0] sdiff(input logic [31:0] a, input logic [31:0] b);
        sdiff = {a[31], a} - {b[31], b};
    endfunction

    function automatic logic [31:0] mag33(input logic [32:0] d);
        logic [32:0] m;
        m = d[32] ? (33'd0 - d) : d;
        mag33 = m[31:0];
    endfunction

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            wrn_pkg::REG_UPDATE_ENABLE: prdata = {31'd0, update_enable_reg};
            wrn_pkg::REG_VECTOR_LENGTH: prdata = {25'd0, vector_length_reg};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            update_enable_reg <= 1'b1;
            vector_length_reg <= 7'd1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                wrn_pkg::REG_UPDATE_ENABLE: update_enable_reg <= pwdata[0];
                wrn_pkg::REG_VECTOR_LENGTH: vector_length_reg <= pwdata[6:0];
                default:                    ;
            endcase
        end
    end

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);

    always_comb
    begin
        if (vector_length_reg == 7'd0)
        begin
            len_c = CW'(1);
        end
        else if (CW'(vector_length_reg) > CW'(MAX_DIMENSIONS))
        begin
            len_c = CW'(MAX_DIMENSIONS);
        end
        else
        begin
            len_c = CW'(vector_length_reg);
        end
        last_now = (CW'(pos_reg) + CW'(1)) >= len_c;

        d_load   = sdiff(x_reg, ram_rdata.mean);
        q32      = div_rsp.quotient[31:0];
        new_mean = d1neg_reg ? (mean_reg - q32) : (mean_reg + q32);
        d_new    = sdiff(x_reg, new_mean);
        d_norm   = sdiff(x_reg, mean_reg);

        add_sum  = (d1neg_reg == d2neg_reg) || (mag1_reg == 32'd0) || (mag2_reg == 32'd0);
        sum_add  = {1'b0, sum_reg} + {1'b0, prod_reg};
        if (add_sum)
        begin
            sum_new = sum_add[64] ? '1 : sum_add[63:0];
        end
        else
        begin
            sum_new = (sum_reg < prod_reg) ? 64'd0 : (sum_reg - prod_reg);
        end

        var_full = div_rsp.quotient[63:16];
        q48      = div_rsp.quotient[47:0];
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '{mean: mean_reg, sum: sum_reg, variance: var_reg};
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '{mean: 32'd0, sum: wrn_pkg::SUM_ONE, variance: wrn_pkg::VAR_ONE};
        end
        else if (state_reg == S_WRITE)
        begin
            ram_we = 1'b1;
        end
        ram_re = accept;
    end

    wrn_ram #(
        .WIDTH(wrn_pkg::ENTRY_W),
        .DEPTH(MAX_DIMENSIONS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(pos_reg),
        .rdata(ram_rdata)
    );

    wrn_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req_reg),
        .rsp  (div_rsp)
    );

    wrn_sqrt u_sqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (sq_req_reg),
        .rsp  (sq_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_reg           <= '0;
            pos_reg           <= '0;
            step_reg          <= '0;
            out_valid_reg     <= 1'b0;
            div_req_reg.start <= 1'b0;
            sq_req_reg.start  <= 1'b0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;
            sq_req_reg.start  <= 1'b0;
            if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + IDX_W'(1);
                    if (clr_reg == IDX_W'(MAX_DIMENSIONS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg    <= in_ch.sample;
                        idx_reg  <= pos_reg;
                        last_reg <= last_now;
                        pos_reg  <= last_now ? '0 : pos_reg + IDX_W'(1);
                        if (update_enable_reg && pos_reg == '0 && step_reg != '1)
                        begin
                            step_reg <= step_reg + 32'd1;
                        end
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (update_enable_reg && step_reg <= 32'd1)
                    begin
                        // First step: the sample becomes the mean.
                        mean_reg  <= x_reg;
                        sum_reg   <= '0;
                        var_reg   <= wrn_pkg::VAR_ONE;
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        mean_reg  <= ram_rdata.mean;
                        sum_reg   <= ram_rdata.sum;
                        var_reg   <= ram_rdata.variance;
                        d1neg_reg <= d_load[32];
                        mag1_reg  <= mag33(d_load);
                        if (!update_enable_reg)
                        begin
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.dividend <= {mag33(d_load), 32'd0};
                            div_req_reg.divisor  <= step_reg;
                            div_req_reg.iters    <= 7'd32;
                            state_reg            <= S_DIV1;
                        end
                    end
                end
                S_DIV1:
                begin
                    if (div_rsp.done)
                    begin
                        mean_reg  <= new_mean;
                        d2neg_reg <= d_new[32];
                        mag2_reg  <= mag33(d_new);
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= mag1_reg * mag2_reg;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    sum_reg              <= sum_new;
                    div_req_reg.start    <= 1'b1;
                    div_req_reg.dividend <= sum_new;
                    div_req_reg.divisor  <= step_reg;
                    div_req_reg.iters    <= 7'd64;
                    state_reg            <= S_DIV2;
                end
                S_DIV2:
                begin
                    if (div_rsp.done)
                    begin
                        var_reg   <= (var_full[47:32] != 16'd0) ? '1 : var_full[31:0];
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    sq_req_reg.start    <= 1'b1;
                    sq_req_reg.radicand <= {var_reg, 16'd0};
                    state_reg           <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (sq_rsp.done)
                    begin
                        if (sq_rsp.root == 24'd0)
                        begin
                            res_reg   <= '0;
                            zero_reg  <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            zero_reg             <= 1'b0;
                            d1neg_reg            <= d_norm[32];
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.dividend <= {mag33(d_norm), 32'd0};
                            div_req_reg.divisor  <= {8'd0, sq_rsp.root};
                            div_req_reg.iters    <= 7'd48;
                            state_reg            <= S_DIV3;
                        end
                    end
                end
                S_DIV3:
                begin
                    if (div_rsp.done)
                    begin
                        if (d1neg_reg)
                        begin
                            res_reg <= (q48 > 48'h0000_8000_0000) ? 32'h8000_0000
                                                                  : 32'd0 - q48[31:0];
                        end
                        else
                        begin
                            res_reg <= (q48 > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                  : q48[31:0];
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_norm_reg  <= res_reg;
                        out_idx_reg   <= 6'(idx_reg);
                        out_last_reg  <= last_reg;
                        out_zero_reg  <= zero_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.normalized     = out_norm_reg;
    assign out_ch.element_index  = out_idx_reg;
    assign out_ch.last_of_vector = out_last_reg;
    assign out_ch.zero_variance  = out_zero_reg;

    `WRN_ASSERT_IMP(a_zero_forces_zero, clk, rst_n,
        out_ch.valid && out_ch.zero_variance, out_ch.normalized == 32'd0)
    `WRN_ASSERT_NXT(a_one_item_in_flight, clk, rst_n,
        in_ch.valid && in_ch.ready, !in_ch.ready)
    `WRN_ASSERT_IMP(a_ram_write_window, clk, rst_n,
        ram_we, state_reg == S_CLEAR || state_reg == S_WRITE)

endmodule
`default_nettype wire

>>> tb/wrn_norm_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module wrn_norm_checker #(
    parameter int MAX_DIMENSIONS = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    wrn_in_if                               in_ch,
    wrn_out_if                              out_ch,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [wrn_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    input  wire logic                       pready,
    output int                              errors,
    output int                              pending
);
    typedef struct packed {
        logic signed [31:0] normalized;
        logic [5:0]         element_index;
        logic               last_of_vector;
        logic               zero_variance;
    } norm_result_t;

    norm_result_t expected_q[$];

    // Shadow copy of the block's configuration and statistics.
    logic               upd_en;
    logic [6:0]         vec_len;
    logic [31:0]        steps;
    logic [5:0]         pos;
    logic signed [31:0] mean_mem [MAX_DIMENSIONS];
    logic [63:0]        sum_mem  [MAX_DIMENSIONS];
    logic [31:0]        var_mem  [MAX_DIMENSIONS];

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    task automatic update_stats(int unsigned idx, longint x);
        logic [63:0] n;
        longint      prior_mean;
        longint      d1;
        longint      d2;
        longint      new_mean;
        logic [63:0] prod;
        logic [63:0] s;
        logic [63:0] v;
        if (steps <= 1)
        begin
            mean_mem[idx] = x[31:0];
            sum_mem[idx] = 0;
            var_mem[idx] = wrn_pkg::VAR_ONE;
            return;
        end
        n = 64'(steps);
        prior_mean = longint'(mean_mem[idx]);
        d1 = x - prior_mean;
        new_mean = d1 < 0 ? prior_mean - longint'(magnitude(d1) / n)
                          : prior_mean + longint'(magnitude(d1) / n);
        mean_mem[idx] = new_mean[31:0];
        d2 = x - new_mean;
        prod = magnitude(d1) * magnitude(d2);
        s = sum_mem[idx];
        if ((d1 < 0) == (d2 < 0) || d1 == 0 || d2 == 0)
            s = (s > ~prod) ? 64'hFFFF_FFFF_FFFF_FFFF : s + prod;
        else
            s = (s < prod) ? 64'd0 : s - prod;
        sum_mem[idx] = s;
        v = (s / n) >> 16;
        var_mem[idx] = v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
    endtask

    task automatic predict_normalized(logic signed [31:0] sample);
        int unsigned  len;
        int unsigned  idx;
        longint       x;
        longint       d;
        logic [63:0]  root;
        logic [63:0]  q;
        norm_result_t r;
        len = vec_len == 0 ? 1 : (vec_len > MAX_DIMENSIONS ? MAX_DIMENSIONS : vec_len);
        idx = pos;
        if (idx >= MAX_DIMENSIONS)
            idx = 0;
        x = longint'(sample);
        if (upd_en)
        begin
            if (idx == 0 && steps != 32'hFFFF_FFFF)
                steps++;
            update_stats(idx, x);
        end
        root = int_sqrt(64'(var_mem[idx]) << 16);
        r.normalized = 0;
        r.zero_variance = (root == 0);
        if (root != 0)
        begin
            d = x - longint'(mean_mem[idx]);
            q = (magnitude(d) << 16) / root;
            if (d < 0)
                r.normalized = q > 64'h8000_0000 ? 32'sh8000_0000 : -q[31:0];
            else
                r.normalized = q > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : q[31:0];
        end
        r.element_index = idx[5:0];
        r.last_of_vector = (idx + 1) >= len;
        pos = r.last_of_vector ? 6'd0 : 6'(idx + 1);
        expected_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_en = 1'b1;
            vec_len = 7'd1;
            steps = 0;
            pos = 0;
            for (int i = 0; i < MAX_DIMENSIONS; i++)
            begin
                mean_mem[i] = 0;
                sum_mem[i] = wrn_pkg::SUM_ONE;
                var_mem[i] = wrn_pkg::VAR_ONE;
            end
            expected_q.delete();
            errors = 0;
        end
        else
        begin
            norm_result_t exp_r;
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == wrn_pkg::REG_UPDATE_ENABLE)
                    upd_en = pwdata[0];
                else if (paddr[2] == wrn_pkg::REG_VECTOR_LENGTH)
                    vec_len = pwdata[6:0];
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    errors++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (out_ch.normalized !== exp_r.normalized)
                    begin
                        $error("normalized: expected %0d, got %0d",
                               exp_r.normalized, out_ch.normalized);
                        errors++;
                    end
                    if (out_ch.element_index !== exp_r.element_index)
                    begin
                        $error("element_index: expected %0d, got %0d",
                               exp_r.element_index, out_ch.element_index);
                        errors++;
                    end
                    if (out_ch.last_of_vector !== exp_r.last_of_vector)
                    begin
                        $error("last_of_vector: expected %0b, got %0b",
                               exp_r.last_of_vector, out_ch.last_of_vector);
                        errors++;
                    end
                    if (out_ch.zero_variance !== exp_r.zero_variance)
                    begin
                        $error("zero_variance: expected %0b, got %0b",
                               exp_r.zero_variance, out_ch.zero_variance);
                        errors++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_normalized(in_ch.sample);
        end
        pending = expected_q.size();
    end
endmodule
`default_nettype wire

>>> tb/welford_running_normalizer_top_test.sv
`timescale 1ns / 100ps
`default_nettype none
module welford_running_normalizer_top_test;
    localparam int DRAIN_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [wrn_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    int errors;
    int pending;

    int gap_pct;
    int stall_pct;
    int hold_cycles;

    wrn_in_if  in_ch ();
    wrn_out_if out_ch ();

    welford_running_normalizer_top dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    wrn_norm_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
    );

    always #10 clk = ~clk;

    initial
    begin
        #200ms;
        $display("welford_running_normalizer_top_test: done, errors");
        $finish;
    end

    // Receiver: a requested hold-off wins over random stalls.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ch.ready = 1'b0;
                hold_cycles--;
            end
            else
                out_ch.ready = $urandom_range(99) >= stall_pct;
        end
    end

    task automatic write_reg(logic [wrn_pkg::ADDR_W-1:0] addr, logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic ue, logic [6:0] len);
        wait_idle();
        write_reg({wrn_pkg::REG_UPDATE_ENABLE, 2'b00}, {31'd0, ue});
        write_reg({wrn_pkg::REG_VECTOR_LENGTH, 2'b00}, {25'd0, len});
    endtask

    // Leaves valid high after acceptance; the caller lowers it when the burst ends.
    task automatic send_sample(logic signed [31:0] s);
        while ($urandom_range(99) < gap_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.sample = s;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic stop_sending();
        in_ch.valid = 1'b0;
    endtask

    function automatic logic [31:0] random_sample(logic [31:0] base);
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return $urandom();
        else if (sel < 11)
            return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else if (sel < 15)
            return base;
        else
            return base + 32'($signed($urandom_range(16'hFFFF) << $urandom_range(4)))
                        - (32'h8000 << 2);
    endfunction

    initial
    begin
        logic [31:0] base;
        logic [6:0]  len;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Update switched on mid-vector while no step has been counted yet.
        set_config(1'b0, 7'd3);
        send_sample(32'h0001_0000);
        stop_sending();
        set_config(1'b1, 7'd3);
        send_sample(32'h0002_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        stop_sending();

        // Constant samples into a single dimension (a length of 0 reads as 1).
        set_config(1'b1, 7'd0);
        repeat (4) send_sample(32'h0003_0000);
        stop_sending();

        // Length beyond the array size, then lowered mid-vector.
        set_config(1'b1, 7'd100);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        stop_sending();
        set_config(1'b1, 7'd5);
        repeat (3) send_sample(32'h0000_8000);
        stop_sending();
        set_config(1'b1, 7'd2);
        send_sample(32'h0001_0000);
        send_sample(32'hFFFF_0000);
        stop_sending();
        set_config(1'b0, 7'd64);
        send_sample(32'h0000_1234);
        send_sample(32'hFFFE_0000);
        stop_sending();

        // Long output hold-off so the block fills and stalls its input.
        set_config(1'b1, 7'd2);
        hold_cycles = 1500;
        repeat (6) send_sample($urandom());
        stop_sending();

        for (int phase = 0; phase < 4; phase++)
        begin
            gap_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 58 : 38) : 0;
            stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 58 : 38) : 0;
            for (int blk = 0; blk < 5; blk++)
            begin
                case ($urandom_range(4))
                    0: len = 7'd1;
                    1: len = 7'd64;
                    2: len = 7'($urandom_range(2, 4));
                    default: len = 7'($urandom_range(1, 127));
                endcase
                set_config($urandom_range(7) != 0, len);
                base = $urandom_range(1)
                     ? $urandom()
                     : 32'($signed($urandom_range(16'hFFFF)) - 32'h8000) << 4;
                repeat (70) send_sample(random_sample(base));
                stop_sending();
            end
        end

        wait_idle();
        if (errors == 0)
            $display("welford_running_normalizer_top_test: done, clean");
        else
            $display("welford_running_normalizer_top_test: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
